/* rtl/fti_pkg.sv */
// fti_pkg: shared constants, codes and types of the fenwick tree inversion counter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package fti_pkg;

  localparam int TREE_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(TREE_DEPTH);
  localparam int IDX_W      = ADDR_W + 2;
  localparam int POS_W      = 11;
  localparam int CFG_W      = 11;
  localparam int DATA_W     = 32;

  localparam logic [CFG_W-1:0] TREE_SIZE_RESET = CFG_W'(1024);

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_CLEAR = 2'd3
  } act_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_Q_RD,
    ST_Q_ACC,
    ST_U_RD,
    ST_U_WR,
    ST_CLEAR,
    ST_DONE
  } fti_state_t;

  typedef struct packed {
    logic load_item;
    logic start_query;
    logic start_update;
    logic mem_rd;
    logic q_acc;
    logic u_wr;
    logic clr_start;
    logic clr_wr;
    logic inv_upd;
    logic result_load;
  } fti_cmd_t;

  typedef struct packed {
    act_t action;
    logic pos_err;
    logic k_zero;
    logic k_in_range;
    logic sweep_last;
    logic out_free;
  } fti_stat_t;

endpackage

/* rtl/fti_intf.sv */
// fti_intf: valid/ready channel interfaces for input items and result items
// depends on fti_pkg for field widths
`timescale 1ns / 1ps

interface fti_in_if import fti_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] amount;

  modport source (output valid, action, position, amount, input ready);
  modport sink (input valid, action, position, amount, output ready);
endinterface

interface fti_out_if import fti_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] prefix_sum;
  logic [DATA_W-1:0]        inversion_total;
  logic                     range_error;

  modport source (output valid, prefix_sum, inversion_total, range_error, input ready);
  modport sink (input valid, prefix_sum, inversion_total, range_error, output ready);
endinterface

/* rtl/fenwick_tree_inversion_counter_core.sv */
// fenwick_tree_inversion_counter_core: top level of the binary indexed tree engine
// depends on fti_pkg, fti_intf, fti_ctrl and fti_datapath
`timescale 1ns / 1ps

// Binary indexed tree over up to 1024 positions held in one single-port-style node
// memory (one read, one write per cycle, registered read). Each visited node passes
// a read state and then an accumulate or write state: a query or the count part of a
// step walks down to index zero, an add or the insert part of a step walks up to the
// active size, each visiting at most log2(size)+1 nodes. The count walk and insert
// walk of a step together visit about log2 n + 1 nodes. One item is worked at a
// time; a finished result waits in the output register while the next item is
// already taken. After reset, and for each clear item, a sweep zeroes the node
// memory one entry per cycle, during which no beat is accepted (configuration
// writes still land). tree_size must be written only while idle; the block itself
// does not enforce this.

module fenwick_tree_inversion_counter_core import fti_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  fti_in_if.sink           in_ch,
  fti_out_if.source        out_ch,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  fti_cmd_t  cmd;
  fti_stat_t stat;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  fti_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fti_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_action           (in_ch.action),
    .in_position         (in_ch.position),
    .in_amount           (in_ch.amount),
    .cmd                 (cmd),
    .stat                (stat),
    .res_ready           (out_ch.ready),
    .res_valid           (out_ch.valid),
    .res_prefix_sum      (out_ch.prefix_sum),
    .res_inversion_total (out_ch.inversion_total),
    .res_range_error     (out_ch.range_error)
  );

endmodule

/* rtl/fti_ctrl.sv */
// fti_ctrl: sequencer for query walks, update walks and clearing sweeps
// depends on fti_pkg; drives fti_datapath through fti_cmd_t
`timescale 1ns / 1ps

module fti_ctrl import fti_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fti_stat_t stat,
  output fti_cmd_t  cmd
);

  fti_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (stat.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (stat.action == ACT_CLEAR) state_nxt = ST_CLEAR;
        else if (stat.pos_err) state_nxt = ST_DONE;
        else if (stat.action == ACT_ADD) state_nxt = ST_U_RD;
        else state_nxt = ST_Q_RD;
      end
      ST_Q_RD: begin
        if (!stat.k_zero) state_nxt = ST_Q_ACC;
        else if (stat.action == ACT_STEP) state_nxt = ST_U_RD;
        else state_nxt = ST_DONE;
      end
      ST_Q_ACC: state_nxt = ST_Q_RD;
      ST_U_RD: begin
        if (stat.k_in_range) state_nxt = ST_U_WR;
        else state_nxt = ST_DONE;
      end
      ST_U_WR: state_nxt = ST_U_RD;
      ST_CLEAR: begin
        if (stat.sweep_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_INIT: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_DECODE: begin
        if (stat.action == ACT_CLEAR) cmd.clr_start = 1'b1;
        else if (!stat.pos_err && stat.action == ACT_ADD) cmd.start_update = 1'b1;
        else if (!stat.pos_err) cmd.start_query = 1'b1;
      end
      ST_Q_RD: begin
        if (!stat.k_zero) cmd.mem_rd = 1'b1;
        else if (stat.action == ACT_STEP) cmd.start_update = 1'b1;
      end
      ST_Q_ACC: cmd.q_acc = 1'b1;
      ST_U_RD: begin
        if (stat.k_in_range) cmd.mem_rd = 1'b1;
        else if (stat.action == ACT_STEP) cmd.inv_upd = 1'b1;
      end
      ST_U_WR: cmd.u_wr = 1'b1;
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_DONE: cmd.result_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/fti_datapath.sv */
// fti_datapath: tree node memory, walk index, accumulator, total and result register
// depends on fti_pkg; commanded by fti_ctrl
`timescale 1ns / 1ps

module fti_datapath import fti_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data,
  input  logic [1:0]               in_action,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_amount,
  input  fti_cmd_t                 cmd,
  output fti_stat_t                stat,
  input  logic                     res_ready,
  output logic                     res_valid,
  output logic signed [DATA_W-1:0] res_prefix_sum,
  output logic [DATA_W-1:0]        res_inversion_total,
  output logic                     res_range_error
);

  logic [CFG_W-1:0]  tree_size_r;
  act_t              action_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] amt_r;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [DATA_W-1:0] acc_r;
  logic [DATA_W-1:0] inv_r;
  logic [DATA_W-1:0] rdata_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_sum_r;
  logic [DATA_W-1:0] out_total_r;
  logic              out_err_r;

  logic [DATA_W-1:0] mem [TREE_DEPTH];

  logic [IDX_W-1:0]  n;
  logic [31:0]       n_ext, pos_ext;
  logic [IDX_W-1:0]  low;
  logic [ADDR_W-1:0] node_addr, waddr;
  logic              we;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W+1:0] inv_sum;
  logic [DATA_W-1:0] inv_sat;
  logic              pos_err;

  // active size clamped to one .. depth
  always_comb begin
    if (tree_size_r == '0) n = IDX_W'(1);
    else if (32'(tree_size_r) > 32'(TREE_DEPTH)) n = IDX_W'(TREE_DEPTH);
    else n = IDX_W'(tree_size_r);
  end

  assign n_ext   = 32'(n);
  assign pos_ext = 32'(pos_r);

  always_comb begin
    unique case (action_r)
      ACT_ADD, ACT_STEP: pos_err = (pos_ext >= n_ext);
      ACT_QUERY:         pos_err = (pos_ext > n_ext);
      ACT_CLEAR:         pos_err = 1'b0;
      default:           pos_err = 1'b0;
    endcase
  end

  assign low       = k_r & (~k_r + IDX_W'(1));
  assign node_addr = ADDR_W'(k_r - IDX_W'(1));

  assign stat.action     = action_r;
  assign stat.pos_err    = pos_err;
  assign stat.k_zero     = (k_r == '0);
  assign stat.k_in_range = (k_r != '0) && (32'(k_r) <= n_ext);
  assign stat.sweep_last = (k_r[ADDR_W-1:0] == ADDR_W'(TREE_DEPTH - 1));
  assign stat.out_free   = !out_valid_r || res_ready;

  // saturating signed add of the smaller-rank count to the total
  assign inv_sum = {2'b00, inv_r} + {{2{acc_r[DATA_W-1]}}, acc_r};
  always_comb begin
    if (inv_sum[DATA_W+1]) inv_sat = '0;
    else if (inv_sum[DATA_W]) inv_sat = '1;
    else inv_sat = inv_sum[DATA_W-1:0];
  end

  assign we    = cmd.u_wr || cmd.clr_wr;
  assign waddr = cmd.clr_wr ? k_r[ADDR_W-1:0] : node_addr;
  assign wdata = cmd.clr_wr ? '0 : rdata_r + amt_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.mem_rd) rdata_r <= mem[node_addr];
  end

  always_comb begin
    priority if (cmd.clr_start) k_nxt = '0;
    else if (cmd.start_query) k_nxt = IDX_W'(pos_r);
    else if (cmd.start_update) k_nxt = IDX_W'(pos_r) + IDX_W'(1);
    else if (cmd.q_acc) k_nxt = k_r - low;
    else if (cmd.u_wr) k_nxt = k_r + low;
    else if (cmd.clr_wr) k_nxt = k_r + IDX_W'(1);
    else k_nxt = k_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_size_r <= TREE_SIZE_RESET;
      k_r         <= '0;
      inv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) tree_size_r <= cfg_wr_data;
      k_r <= k_nxt;
      if (cmd.clr_start) inv_r <= '0;
      else if (cmd.inv_upd) inv_r <= inv_sat;
      if (cmd.result_load) out_valid_r <= 1'b1;
      else if (res_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      action_r <= act_t'(in_action);
      pos_r    <= in_position;
      amt_r    <= (act_t'(in_action) == ACT_STEP) ? DATA_W'(1) : DATA_W'(in_amount);
      acc_r    <= '0;
    end else if (cmd.q_acc) begin
      acc_r <= acc_r + rdata_r;
    end
    if (cmd.result_load) begin
      out_sum_r   <= acc_r;
      out_total_r <= inv_r;
      out_err_r   <= pos_err;
    end
  end

  assign res_valid           = out_valid_r;
  assign res_prefix_sum      = $signed(out_sum_r);
  assign res_inversion_total = out_total_r;
  assign res_range_error     = out_err_r;

endmodule

/* rtl/fti_checker.sv */
// fti_checker: port-level assertions for the fenwick tree inversion counter
// depends on fti_pkg; bound to fenwick_tree_inversion_counter_core
`timescale 1ns / 1ps

module fti_checker import fti_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_prefix_sum,
  input logic [DATA_W-1:0]        out_inversion_total,
  input logic                     out_range_error
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_prefix_sum)
      && $stable(out_inversion_total) && $stable(out_range_error))
    else $error("result beat changed while stalled");

  // rejected items report a zero sum
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_prefix_sum == '0)
    else $error("range error with nonzero sum");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");

  // clearing sweep follows reset
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("beat accepted before memory sweep");

endmodule

bind fenwick_tree_inversion_counter_core fti_checker u_fti_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_prefix_sum      (out_ch.prefix_sum),
  .out_inversion_total (out_ch.inversion_total),
  .out_range_error     (out_ch.range_error)
);
